@@ rtl/core/rect_blit_address_generator_top_macros.svh @@
// assertion macros shared by the blitter checker
`ifndef RECT_BLIT_ADDRESS_GENERATOR_TOP_MACROS_SVH
`define RECT_BLIT_ADDRESS_GENERATOR_TOP_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define RBAG_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define RBAG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/rbag_pkg.sv @@
// shared constants, codes and types of the rectangle blit address generator
`default_nettype none

package rbag_pkg;

   // rectangle limits and the counter widths that follow from them
   localparam int MAX_WIDTH  = 8192;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int WID_W      = COL_W + 1;
   localparam int HGT_W      = ROW_W + 1;

   // field widths
   localparam int PITCH_W    = 14;
   localparam int X_W        = 13;
   localparam int Y_W        = 12;
   localparam int RECT_W_W   = 14;
   localparam int RECT_H_W   = 13;
   localparam int COLOR_W    = 32;
   localparam int PIXEL_W    = 32;
   localparam int INDEX_W    = 25;
   localparam int FUNC_W     = 2;
   localparam int KIND_W     = 2;

   // absolute row and column sums
   localparam int ROWSUM_W   = ((Y_W > ROW_W) ? Y_W : ROW_W) + 1;
   localparam int COLSUM_W   = ((X_W > COL_W) ? X_W : COL_W) + 1;

   // register file
   localparam int NUM_REGS    = 8;
   localparam int REG_IDX_W   = $clog2(NUM_REGS);
   localparam int CSR_ADDR_W  = REG_IDX_W + 2;
   localparam int CSR_DATA_W  = 32;
   localparam int PITCH_RESET = 1024;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_FILL    = 2'd0,
      FUNC_COPY    = 2'd1,
      FUNC_IMAGE   = 2'd2,
      FUNC_ADVANCE = 2'd3
   } func_type;

   typedef enum logic [KIND_W-1:0] {
      OP_FILL  = 2'd0,
      OP_COPY  = 2'd1,
      OP_IMAGE = 2'd2
   } op_kind_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_LINE_PITCH  = 3'd0,
      REG_DEST_X      = 3'd1,
      REG_DEST_Y      = 3'd2,
      REG_SOURCE_X    = 3'd3,
      REG_SOURCE_Y    = 3'd4,
      REG_RECT_WIDTH  = 3'd5,
      REG_RECT_HEIGHT = 3'd6,
      REG_FILL_COLOR  = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [PITCH_W-1:0]  line_pitch;
      logic [X_W-1:0]      dest_x;
      logic [Y_W-1:0]      dest_y;
      logic [X_W-1:0]      source_x;
      logic [Y_W-1:0]      source_y;
      logic [RECT_W_W-1:0] rect_width;
      logic [RECT_H_W-1:0] rect_height;
      logic [COLOR_W-1:0]  fill_color;
   } cfg_type;

   // one pixel operation between the walker and the index stage
   typedef struct packed {
      logic                valid;
      op_kind_type         kind;
      logic [ROWSUM_W-1:0] dest_row;
      logic [COLSUM_W-1:0] dest_col;
      logic [ROWSUM_W-1:0] source_row;
      logic [COLSUM_W-1:0] source_col;
      logic [PIXEL_W-1:0]  pixel;
      logic                last;
   } op_type;

endpackage

`default_nettype wire

@@ rtl/core/rect_blit_address_generator_top.sv @@
// Rectangle blit address generator: top level.
// Start requests (fill, copy, image) arm a walk over the rectangle set up in
// the csr registers; each later advance request yields one pixel operation on
// the rsp channel, with destination index (row+y)*pitch+x+column, the source
// index for copy, the value to write and a last flag on the final pixel.
// Start requests and advances while idle produce no response.
// Channels: req and rsp use valid/stall; a request moves when valid is high
// and stall is low. The csr port is apb-style, always ready, 32-bit data.
// An accepted advance passes the walker operation register and then the result
// register, from which its response is valid on rsp.
// Throughput: one request per cycle while rsp_stall is low, set by the walker
// step and the registered multiply-add stage; a stalled response holds both.
// Stall: a stalled response holds in the result register while the next
// operation waits in the walker stage; req_stall rises only when both are
// full, so no operation is lost or repeated.
// Reset: synchronous, clears the walk (idle), both stages, and loads pitch 1024
// with all other registers zero.
`default_nettype none

module rect_blit_address_generator_top import rbag_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [PIXEL_W-1:0]    req_pixel_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [KIND_W-1:0]     rsp_op_kind,
   output logic [INDEX_W-1:0]    rsp_dest_index,
   output logic [INDEX_W-1:0]    rsp_source_index,
   output logic [COLOR_W-1:0]    rsp_write_value,
   output logic                  rsp_last_op,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;
   op_type  op;
   logic    op_take;

   rbag_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rbag_walker u_walker (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_pixel_in (req_pixel_in),
      .op_take      (op_take),
      .op           (op)
   );

   rbag_index u_index (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .op               (op),
      .op_take          (op_take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_op_kind      (rsp_op_kind),
      .rsp_dest_index   (rsp_dest_index),
      .rsp_source_index (rsp_source_index),
      .rsp_write_value  (rsp_write_value),
      .rsp_last_op      (rsp_last_op)
   );

endmodule

`default_nettype wire

@@ rtl/core/rbag_csr.sv @@
// configuration registers with an apb-style access port
`default_nettype none

module rbag_csr import rbag_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_idx;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_LINE_PITCH:  cfg_in.line_pitch  = csr_pwdata[PITCH_W-1:0];
            REG_DEST_X:      cfg_in.dest_x      = csr_pwdata[X_W-1:0];
            REG_DEST_Y:      cfg_in.dest_y      = csr_pwdata[Y_W-1:0];
            REG_SOURCE_X:    cfg_in.source_x    = csr_pwdata[X_W-1:0];
            REG_SOURCE_Y:    cfg_in.source_y    = csr_pwdata[Y_W-1:0];
            REG_RECT_WIDTH:  cfg_in.rect_width  = csr_pwdata[RECT_W_W-1:0];
            REG_RECT_HEIGHT: cfg_in.rect_height = csr_pwdata[RECT_H_W-1:0];
            REG_FILL_COLOR:  cfg_in.fill_color  = csr_pwdata[COLOR_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{line_pitch: PITCH_W'(PITCH_RESET), default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_LINE_PITCH:  csr_prdata = CSR_DATA_W'(cfg_ff.line_pitch);
         REG_DEST_X:      csr_prdata = CSR_DATA_W'(cfg_ff.dest_x);
         REG_DEST_Y:      csr_prdata = CSR_DATA_W'(cfg_ff.dest_y);
         REG_SOURCE_X:    csr_prdata = CSR_DATA_W'(cfg_ff.source_x);
         REG_SOURCE_Y:    csr_prdata = CSR_DATA_W'(cfg_ff.source_y);
         REG_RECT_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.rect_width);
         REG_RECT_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.rect_height);
         REG_FILL_COLOR:  csr_prdata = CSR_DATA_W'(cfg_ff.fill_color);
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/rbag_walker.sv @@
// rectangle walk state and the registered pixel operation it produces
`default_nettype none

module rbag_walker import rbag_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [PIXEL_W-1:0] req_pixel_in,
   input  logic               op_take,
   output op_type             op
);

   logic        busy_ff,      busy_in;
   op_kind_type mode_ff,      mode_in;
   logic [COL_W-1:0] col_ff,  col_in;
   logic [ROW_W-1:0] row_ff,  row_in;
   logic        cols_desc_ff, cols_desc_in;
   logic        rows_desc_ff, rows_desc_in;
   op_type      op_ff,        op_in;

   logic [WID_W-1:0] w_eff;
   logic [HGT_W-1:0] h_eff;
   logic             stage_ready;
   logic             accept;
   logic             col_end;
   logic             row_end;
   func_type         func;

   assign func        = func_type'(req_func);
   assign stage_ready = !op_ff.valid || op_take;
   assign accept      = req_valid && stage_ready;
   assign req_stall   = !stage_ready;
   assign op          = op_ff;

   // oversize rectangles saturate
   always_comb begin
      if (32'(cfg.rect_width) > 32'(MAX_WIDTH)) begin
         w_eff = WID_W'(MAX_WIDTH);
      end else begin
         w_eff = WID_W'(cfg.rect_width);
      end
      if (32'(cfg.rect_height) > 32'(MAX_HEIGHT)) begin
         h_eff = HGT_W'(MAX_HEIGHT);
      end else begin
         h_eff = HGT_W'(cfg.rect_height);
      end
   end

   // end of row and end of rectangle against the current geometry
   always_comb begin
      if (cols_desc_ff) begin
         col_end = (col_ff == '0);
      end else begin
         col_end = (WID_W'(col_ff) + WID_W'(1)) >= w_eff;
      end
      if (rows_desc_ff) begin
         row_end = (row_ff == '0);
      end else begin
         row_end = (HGT_W'(row_ff) + HGT_W'(1)) >= h_eff;
      end
   end

   // walk step for one request
   always_comb begin
      busy_in      = busy_ff;
      mode_in      = mode_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cols_desc_in = cols_desc_ff;
      rows_desc_in = rows_desc_ff;
      op_in        = op_ff;
      if (stage_ready) begin
         op_in.valid = 1'b0;
      end
      if (accept) begin
         if (func != FUNC_ADVANCE) begin
            // start: arm a new walk, dropping any walk in progress
            busy_in = 1'b0;
            mode_in = op_kind_type'(req_func);
            if ((w_eff != '0) && (h_eff != '0)) begin
               rows_desc_in = (func == FUNC_COPY) && (cfg.dest_y >= cfg.source_y);
               cols_desc_in = (func == FUNC_COPY) && (cfg.dest_x >= cfg.source_x);
               row_in  = rows_desc_in ? ROW_W'(h_eff - HGT_W'(1)) : '0;
               col_in  = cols_desc_in ? COL_W'(w_eff - WID_W'(1)) : '0;
               busy_in = 1'b1;
            end
         end else if (busy_ff) begin
            // advance: emit one operation and step
            op_in.valid      = 1'b1;
            op_in.kind       = mode_ff;
            op_in.dest_row   = ROWSUM_W'(row_ff) + ROWSUM_W'(cfg.dest_y);
            op_in.dest_col   = COLSUM_W'(col_ff) + COLSUM_W'(cfg.dest_x);
            op_in.source_row = ROWSUM_W'(row_ff) + ROWSUM_W'(cfg.source_y);
            op_in.source_col = COLSUM_W'(col_ff) + COLSUM_W'(cfg.source_x);
            op_in.pixel      = req_pixel_in;
            op_in.last       = col_end && row_end;
            if (col_end && row_end) begin
               busy_in = 1'b0;
            end else if (col_end) begin
               if (cols_desc_ff) begin
                  col_in = (w_eff == '0) ? '0 : COL_W'(w_eff - WID_W'(1));
               end else begin
                  col_in = '0;
               end
               row_in = rows_desc_ff ? (row_ff - ROW_W'(1)) : (row_ff + ROW_W'(1));
            end else begin
               col_in = cols_desc_ff ? (col_ff - COL_W'(1)) : (col_ff + COL_W'(1));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         mode_ff      <= OP_FILL;
         col_ff       <= '0;
         row_ff       <= '0;
         cols_desc_ff <= 1'b0;
         rows_desc_ff <= 1'b0;
         op_ff.valid  <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         mode_ff      <= mode_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         cols_desc_ff <= cols_desc_in;
         rows_desc_ff <= rows_desc_in;
         op_ff.valid  <= op_in.valid;
      end
      // payload fields carry no reset
      op_ff.kind       <= op_in.kind;
      op_ff.dest_row   <= op_in.dest_row;
      op_ff.dest_col   <= op_in.dest_col;
      op_ff.source_row <= op_in.source_row;
      op_ff.source_col <= op_in.source_col;
      op_ff.pixel      <= op_in.pixel;
      op_ff.last       <= op_in.last;
   end

endmodule

`default_nettype wire

@@ rtl/core/rbag_index.sv @@
// pixel index multiply-add and the result register
`default_nettype none

module rbag_index import rbag_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  op_type             op,
   output logic               op_take,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [KIND_W-1:0]  rsp_op_kind,
   output logic [INDEX_W-1:0] rsp_dest_index,
   output logic [INDEX_W-1:0] rsp_source_index,
   output logic [COLOR_W-1:0] rsp_write_value,
   output logic               rsp_last_op
);

   logic                        rsp_valid_ff,  rsp_valid_in;
   op_kind_type                 kind_ff;
   logic [INDEX_W-1:0]          dest_ff,       dest_in;
   logic [INDEX_W-1:0]          source_ff,     source_in;
   logic [COLOR_W-1:0]          value_ff,      value_in;
   logic                        last_ff;
   logic [ROWSUM_W+PITCH_W-1:0] dest_prod;
   logic [ROWSUM_W+PITCH_W-1:0] source_prod;

   // result register is free or being emptied this cycle
   assign op_take = !rsp_valid_ff || !rsp_stall;

   // row times pitch plus column, wrapping at the index width
   always_comb begin
      dest_prod   = (ROWSUM_W + PITCH_W)'(op.dest_row) * (ROWSUM_W + PITCH_W)'(cfg.line_pitch);
      source_prod = (ROWSUM_W + PITCH_W)'(op.source_row)
                    * (ROWSUM_W + PITCH_W)'(cfg.line_pitch);
      dest_in     = INDEX_W'(dest_prod) + INDEX_W'(op.dest_col);
      if (op.kind == OP_COPY) begin
         source_in = INDEX_W'(source_prod) + INDEX_W'(op.source_col);
      end else begin
         source_in = '0;
      end
   end

   // value written per operation kind
   always_comb begin
      unique case (op.kind)
         OP_FILL:  value_in = cfg.fill_color;
         OP_IMAGE: value_in = op.pixel;
         default:  value_in = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (op_take) begin
         rsp_valid_in = op.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (op_take && op.valid) begin
         kind_ff   <= op.kind;
         dest_ff   <= dest_in;
         source_ff <= source_in;
         value_ff  <= value_in;
         last_ff   <= op.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_op_kind      = kind_ff;
   assign rsp_dest_index   = dest_ff;
   assign rsp_source_index = source_ff;
   assign rsp_write_value  = value_ff;
   assign rsp_last_op      = last_ff;

endmodule

`default_nettype wire

@@ rtl/core/rbag_checker.sv @@
// port-level checks of the blit address generator, bound to the top level
`default_nettype none
`include "rect_blit_address_generator_top_macros.svh"

module rbag_checker import rbag_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [FUNC_W-1:0]  req_func,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [KIND_W-1:0]  rsp_op_kind,
   input logic [INDEX_W-1:0] rsp_dest_index,
   input logic [INDEX_W-1:0] rsp_source_index,
   input logic [COLOR_W-1:0] rsp_write_value,
   input logic               rsp_last_op
);

   // a stalled response keeps its contents
   `RBAG_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_op_kind) && $stable(rsp_dest_index) && $stable(rsp_source_index) && $stable(rsp_write_value) && $stable(rsp_last_op), "stalled response changed")

   // only copy carries a source index
   `RBAG_ASSERT_IMPL(a_src_zero, rsp_valid && (rsp_op_kind != OP_COPY), rsp_source_index == '0, "source index set outside copy")

   // copy writes no value
   `RBAG_ASSERT_IMPL(a_copy_value, rsp_valid && (rsp_op_kind == OP_COPY), rsp_write_value == '0, "copy carries a write value")

   // a fresh response needs an earlier accepted advance
   `RBAG_ASSERT_IMPL(a_rsp_source, $rose(rsp_valid), $past(req_valid && !req_stall && (req_func == FUNC_ADVANCE), 2), "response without advance")

endmodule

bind rect_blit_address_generator_top rbag_checker u_rbag_checker (.*);

`default_nettype wire
